>>> sv/assert_macros.svh
// Assertion helpers shared by the RTL files. Every check is clocked on clk
// and switched off while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// A condition in one cycle that implies another in the following cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/mtep_pkg.sv
package mtep_pkg;

  // Parser position inside the track byte stream.
  typedef enum logic [3:0] {
    PH_DELTA,
    PH_STATUS,
    PH_META_TYPE,
    PH_META_LEN,
    PH_META_SKIP,
    PH_TEMPO,
    PH_SYSEX_LEN,
    PH_SYSEX_SKIP,
    PH_DATA1,
    PH_DATA2,
    PH_HALT
  } phase_t;

  // Result kinds.
  localparam logic [2:0] K_NOTE_ON  = 3'd0;
  localparam logic [2:0] K_NOTE_OFF = 3'd1;
  localparam logic [2:0] K_PROGRAM  = 3'd2;
  localparam logic [2:0] K_CONTROL  = 3'd3;
  localparam logic [2:0] K_BEND     = 3'd4;
  localparam logic [2:0] K_TEMPO    = 3'd5;
  localparam logic [2:0] K_END      = 3'd6;
  localparam logic [2:0] K_ERROR    = 3'd7;

  // Error codes.
  localparam logic [2:0] E_DELTA    = 3'd0;
  localparam logic [2:0] E_RUNNING  = 3'd1;
  localparam logic [2:0] E_META     = 3'd2;
  localparam logic [2:0] E_META_LEN = 3'd3;
  localparam logic [2:0] E_SYSEX    = 3'd4;
  localparam logic [2:0] E_CHANNEL  = 3'd5;

  // Status bytes and channel message opcodes (high nibble).
  localparam logic [7:0] ST_META      = 8'hFF;
  localparam logic [7:0] ST_SYSEX     = 8'hF0;
  localparam logic [7:0] ST_SYSEX_ESC = 8'hF7;
  localparam logic [3:0] OP_NOTE_OFF  = 4'h8;
  localparam logic [3:0] OP_NOTE_ON   = 4'h9;
  localparam logic [3:0] OP_CONTROL   = 4'hB;
  localparam logic [3:0] OP_PROGRAM   = 4'hC;
  localparam logic [3:0] OP_CHAN_AT   = 4'hD;
  localparam logic [3:0] OP_BEND      = 4'hE;
  localparam logic [3:0] OP_SYSTEM    = 4'hF;

  // Meta event types.
  localparam logic [7:0] META_TEMPO = 8'h51;
  localparam logic [7:0] META_END   = 8'h2F;

  // Field widths fixed by the result format.
  localparam int EVT_TICK_W = 48;
  localparam int ORDER_W    = 32;

  // Decoded result of one accepted byte or chunk end.
  typedef struct packed {
    logic        valid;
    logic [2:0]  kind;
    logic [3:0]  channel;
    logic [7:0]  data_first;
    logic [7:0]  data_second;
    logic [23:0] tempo_us;
    logic        is_event;
    logic [2:0]  error_code;
    logic        ord_take;
  } result_t;

endpackage

>>> sv/midi_track_event_parser.sv
// MIDI track event parser.
// Input channel (in_valid/in_ready): one transfer per track byte (cmd = 0,
// byte in byte_value) or one chunk-end mark (cmd = 1). Output channel
// (out_valid/out_ready): decoded note on/off, program, control, bend and
// tempo events, track end and error results, at most one per input transfer.
// Each input transfer is decoded in the cycle it is accepted, so a result
// appears on the output register in the next cycle. One input transfer is
// taken every cycle as long as the output register is empty or being
// emptied in the same cycle; the single output register sets this limit.
// When the receiver stalls with a result pending, in_ready falls and the
// parser holds its state until the result is taken.
// After reset, and after every chunk end, the parser expects a delta time,
// with tick, running status and all partial fields cleared; the event order
// counter is cleared only by reset. After a track end or error result the
// remaining bytes of the chunk are consumed without any result.
`include "assert_macros.svh"

module midi_track_event_parser #(
  parameter int TICK_WIDTH       = 48,
  parameter int VARLEN_MAX_BYTES = 5
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        cmd,
  input  logic [7:0]  byte_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  kind,
  output logic [3:0]  channel,
  output logic [7:0]  data_first,
  output logic [7:0]  data_second,
  output logic [23:0] tempo_us,
  output logic [47:0] event_tick,
  output logic [31:0] order_number,
  output logic [2:0]  error_code
);

  localparam int VL_W  = 7 * VARLEN_MAX_BYTES;
  localparam int CNT_W = $clog2(VARLEN_MAX_BYTES + 1);

  // Parser state.
  mtep_pkg::phase_t     phase, phase_next;
  logic [TICK_WIDTH-1:0] tick_total, tick_next;
  logic [VL_W-1:0]      varlen_accum, varlen_accum_next;
  logic [CNT_W-1:0]     varlen_count, varlen_count_next;
  logic [7:0]           running_status, running_status_next;
  logic [7:0]           current_status, current_status_next;
  logic [7:0]           held_data, held_data_next;
  logic [7:0]           meta_type, meta_type_next;
  logic [31:0]          skip_remaining, skip_remaining_next;
  logic [23:0]          tempo_accum, tempo_accum_next;
  logic [31:0]          order_count, order_count_next;

  mtep_pkg::result_t    res;
  logic                 take;

  // Shared decode signals.
  logic [VL_W-1:0]       vl_accum_new;
  logic [CNT_W-1:0]      vl_count_new;
  logic [39:0]           vl_wide;
  logic [31:0]           vl_value;
  logic                  vl_last, vl_fail, vl_phase;
  logic [TICK_WIDTH:0]   tick_sum;
  logic [TICK_WIDTH-1:0] tick_sat;
  logic                  rs_ok;
  logic [7:0]            st_eff;
  logic [7:0]            cd_status;
  logic [3:0]            cd_op;
  logic [7:0]            cd_d1, cd_d2;
  logic [31:0]           skip_dec;
  logic                  skip_zero;
  logic [23:0]           tempo_new;
  logic [63:0]           tick_ext;

  assign in_ready = !out_valid || out_ready;
  assign take     = in_valid && in_ready;

  // Variable-length quantity step: seven bits per byte, top bit continues.
  assign vl_accum_new = {varlen_accum[VL_W-8:0], byte_value[6:0]};
  assign vl_count_new = varlen_count + CNT_W'(1);
  assign vl_wide      = 40'(vl_accum_new);
  assign vl_value     = vl_wide[31:0];
  assign vl_last      = !byte_value[7];
  assign vl_fail      = vl_last ? (|vl_wide[39:32])
                                : (vl_count_new >= CNT_W'(VARLEN_MAX_BYTES));
  assign vl_phase     = (phase == mtep_pkg::PH_DELTA) || (phase == mtep_pkg::PH_META_LEN) ||
                        (phase == mtep_pkg::PH_SYSEX_LEN);

  // Saturating tick accumulation.
  assign tick_sum = {1'b0, tick_total} + (TICK_WIDTH + 1)'(vl_value);
  assign tick_sat = tick_sum[TICK_WIDTH] ? '1 : tick_sum[TICK_WIDTH-1:0];

  // Running status is usable only when it holds a channel status.
  assign rs_ok  = running_status[7] && (running_status[7:4] != mtep_pkg::OP_SYSTEM);
  assign st_eff = byte_value[7] ? byte_value : running_status;

  // Operands of a completed channel message.
  assign cd_status = (phase == mtep_pkg::PH_STATUS) ? running_status : current_status;
  assign cd_op     = cd_status[7:4];
  assign cd_d1     = (phase == mtep_pkg::PH_DATA2) ? held_data : byte_value;
  assign cd_d2     = (phase == mtep_pkg::PH_DATA2) ? byte_value : 8'h00;

  // Countdown of skipped or tempo bytes.
  assign skip_dec  = skip_remaining - 32'd1;
  assign skip_zero = (skip_dec == 32'd0);
  assign tempo_new = {tempo_accum[15:0], byte_value};

  // Result decode for the byte or chunk end on the input.
  always_comb begin : p_result
    logic chan_done;
    res       = '0;
    chan_done = 1'b0;
    if (cmd) begin
      res.valid = 1'b1;
      res.kind  = mtep_pkg::K_ERROR;
      unique case (phase)
        mtep_pkg::PH_DELTA: begin
          res.kind       = (varlen_count != '0) ? mtep_pkg::K_ERROR : mtep_pkg::K_END;
          res.error_code = mtep_pkg::E_DELTA;
        end
        mtep_pkg::PH_STATUS:    res.kind = mtep_pkg::K_END;
        mtep_pkg::PH_META_TYPE: res.error_code = mtep_pkg::E_META;
        mtep_pkg::PH_META_LEN, mtep_pkg::PH_META_SKIP, mtep_pkg::PH_TEMPO:
          res.error_code = mtep_pkg::E_META_LEN;
        mtep_pkg::PH_SYSEX_LEN, mtep_pkg::PH_SYSEX_SKIP:
          res.error_code = mtep_pkg::E_SYSEX;
        mtep_pkg::PH_DATA1, mtep_pkg::PH_DATA2:
          res.error_code = mtep_pkg::E_CHANNEL;
        default: res = '0;
      endcase
    end else begin
      unique case (phase)
        mtep_pkg::PH_DELTA: begin
          if (vl_fail) begin
            res.valid      = 1'b1;
            res.kind       = mtep_pkg::K_ERROR;
            res.error_code = mtep_pkg::E_DELTA;
          end
        end
        mtep_pkg::PH_STATUS: begin
          if (!byte_value[7] && !rs_ok) begin
            res.valid      = 1'b1;
            res.kind       = mtep_pkg::K_ERROR;
            res.error_code = mtep_pkg::E_RUNNING;
          end else if (!byte_value[7] &&
                       (cd_op == mtep_pkg::OP_PROGRAM || cd_op == mtep_pkg::OP_CHAN_AT)) begin
            chan_done = 1'b1;
          end
        end
        mtep_pkg::PH_META_LEN: begin
          if (vl_fail) begin
            res.valid      = 1'b1;
            res.kind       = mtep_pkg::K_ERROR;
            res.error_code = mtep_pkg::E_META_LEN;
          end else if (vl_last && vl_value == 32'd0 && meta_type == mtep_pkg::META_END) begin
            res.valid = 1'b1;
            res.kind  = mtep_pkg::K_END;
          end
        end
        mtep_pkg::PH_META_SKIP: begin
          if (skip_zero && meta_type == mtep_pkg::META_END) begin
            res.valid = 1'b1;
            res.kind  = mtep_pkg::K_END;
          end
        end
        mtep_pkg::PH_TEMPO: begin
          if (skip_zero) begin
            res.valid    = 1'b1;
            res.kind     = mtep_pkg::K_TEMPO;
            res.tempo_us = tempo_new;
            res.is_event = 1'b1;
            res.ord_take = 1'b1;
          end
        end
        mtep_pkg::PH_SYSEX_LEN: begin
          if (vl_fail) begin
            res.valid      = 1'b1;
            res.kind       = mtep_pkg::K_ERROR;
            res.error_code = mtep_pkg::E_SYSEX;
          end
        end
        mtep_pkg::PH_DATA1:
          chan_done = (cd_op == mtep_pkg::OP_PROGRAM) || (cd_op == mtep_pkg::OP_CHAN_AT);
        mtep_pkg::PH_DATA2: chan_done = 1'b1;
        default: chan_done = 1'b0;
      endcase

      // A completed channel message: channel pressure gives nothing, key
      // pressure only uses up an order number.
      if (chan_done) begin
        res.channel     = cd_status[3:0];
        res.data_first  = cd_d1;
        res.data_second = cd_d2;
        res.is_event    = 1'b1;
        res.ord_take    = (cd_op != mtep_pkg::OP_CHAN_AT);
        res.valid       = 1'b1;
        unique case (cd_op)
          mtep_pkg::OP_PROGRAM:  res.kind = mtep_pkg::K_PROGRAM;
          mtep_pkg::OP_NOTE_OFF: res.kind = mtep_pkg::K_NOTE_OFF;
          mtep_pkg::OP_NOTE_ON:
            res.kind = (cd_d2 == 8'h00) ? mtep_pkg::K_NOTE_OFF : mtep_pkg::K_NOTE_ON;
          mtep_pkg::OP_CONTROL:  res.kind = mtep_pkg::K_CONTROL;
          mtep_pkg::OP_BEND:     res.kind = mtep_pkg::K_BEND;
          default:               res.valid = 1'b0;
        endcase
      end
    end
  end

  // Next state of the parser.
  always_comb begin
    phase_next          = phase;
    tick_next           = tick_total;
    varlen_accum_next   = varlen_accum;
    varlen_count_next   = varlen_count;
    running_status_next = running_status;
    current_status_next = current_status;
    held_data_next      = held_data;
    meta_type_next      = meta_type;
    skip_remaining_next = skip_remaining;
    tempo_accum_next    = tempo_accum;
    order_count_next    = order_count;
    if (take && cmd) begin
      phase_next          = mtep_pkg::PH_DELTA;
      tick_next           = '0;
      varlen_accum_next   = '0;
      varlen_count_next   = '0;
      running_status_next = 8'h00;
      current_status_next = 8'h00;
      held_data_next      = 8'h00;
      meta_type_next      = 8'h00;
      skip_remaining_next = 32'd0;
      tempo_accum_next    = 24'd0;
    end else if (take) begin
      if (res.ord_take && order_count != '1) begin
        order_count_next = order_count + 32'd1;
      end
      if (vl_phase) begin
        varlen_accum_next = (vl_last || vl_fail) ? '0 : vl_accum_new;
        varlen_count_next = (vl_last || vl_fail) ? '0 : vl_count_new;
      end
      unique case (phase)
        mtep_pkg::PH_DELTA: begin
          if (vl_fail) begin
            phase_next = mtep_pkg::PH_HALT;
          end else if (vl_last) begin
            tick_next  = tick_sat;
            phase_next = mtep_pkg::PH_STATUS;
          end
        end
        mtep_pkg::PH_STATUS: begin
          if (!byte_value[7] && !rs_ok) begin
            phase_next = mtep_pkg::PH_HALT;
          end else begin
            if (!byte_value[7]) begin
              held_data_next = byte_value;
            end else if (byte_value[7:4] != mtep_pkg::OP_SYSTEM) begin
              running_status_next = byte_value;
            end else begin
              running_status_next = 8'h00;
            end
            current_status_next = st_eff;
            priority if (st_eff == mtep_pkg::ST_META) begin
              phase_next = mtep_pkg::PH_META_TYPE;
            end else if (st_eff == mtep_pkg::ST_SYSEX || st_eff == mtep_pkg::ST_SYSEX_ESC) begin
              phase_next = mtep_pkg::PH_SYSEX_LEN;
            end else if (st_eff[7:4] == mtep_pkg::OP_SYSTEM) begin
              phase_next = mtep_pkg::PH_DELTA;
            end else if (st_eff[7:4] == mtep_pkg::OP_PROGRAM ||
                         st_eff[7:4] == mtep_pkg::OP_CHAN_AT) begin
              phase_next = byte_value[7] ? mtep_pkg::PH_DATA1 : mtep_pkg::PH_DELTA;
            end else begin
              phase_next = byte_value[7] ? mtep_pkg::PH_DATA1 : mtep_pkg::PH_DATA2;
            end
          end
        end
        mtep_pkg::PH_META_TYPE: begin
          meta_type_next = byte_value;
          phase_next     = mtep_pkg::PH_META_LEN;
        end
        mtep_pkg::PH_META_LEN: begin
          if (vl_fail) begin
            phase_next = mtep_pkg::PH_HALT;
          end else if (vl_last) begin
            skip_remaining_next = vl_value;
            tempo_accum_next    = 24'd0;
            priority if (meta_type == mtep_pkg::META_TEMPO && vl_value == 32'd3) begin
              phase_next = mtep_pkg::PH_TEMPO;
            end else if (vl_value == 32'd0) begin
              phase_next = (meta_type == mtep_pkg::META_END) ? mtep_pkg::PH_HALT
                                                             : mtep_pkg::PH_DELTA;
            end else begin
              phase_next = mtep_pkg::PH_META_SKIP;
            end
          end
        end
        mtep_pkg::PH_META_SKIP: begin
          skip_remaining_next = skip_dec;
          if (skip_zero) begin
            phase_next = (meta_type == mtep_pkg::META_END) ? mtep_pkg::PH_HALT
                                                           : mtep_pkg::PH_DELTA;
          end
        end
        mtep_pkg::PH_TEMPO: begin
          tempo_accum_next    = tempo_new;
          skip_remaining_next = skip_dec;
          if (skip_zero) begin
            phase_next = mtep_pkg::PH_DELTA;
          end
        end
        mtep_pkg::PH_SYSEX_LEN: begin
          if (vl_fail) begin
            phase_next = mtep_pkg::PH_HALT;
          end else if (vl_last) begin
            skip_remaining_next = vl_value;
            phase_next = (vl_value == 32'd0) ? mtep_pkg::PH_DELTA : mtep_pkg::PH_SYSEX_SKIP;
          end
        end
        mtep_pkg::PH_SYSEX_SKIP: begin
          skip_remaining_next = skip_dec;
          if (skip_zero) begin
            phase_next = mtep_pkg::PH_DELTA;
          end
        end
        mtep_pkg::PH_DATA1: begin
          held_data_next = byte_value;
          if (cd_op == mtep_pkg::OP_PROGRAM || cd_op == mtep_pkg::OP_CHAN_AT) begin
            phase_next = mtep_pkg::PH_DELTA;
          end else begin
            phase_next = mtep_pkg::PH_DATA2;
          end
        end
        mtep_pkg::PH_DATA2: phase_next = mtep_pkg::PH_DELTA;
        default: phase_next = phase;
      endcase
    end
  end

  // Parser state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= mtep_pkg::PH_DELTA;
      tick_total     <= '0;
      varlen_accum   <= '0;
      varlen_count   <= '0;
      running_status <= 8'h00;
      current_status <= 8'h00;
      held_data      <= 8'h00;
      meta_type      <= 8'h00;
      skip_remaining <= 32'd0;
      tempo_accum    <= 24'd0;
      order_count    <= 32'd0;
    end else begin
      phase          <= phase_next;
      tick_total     <= tick_next;
      varlen_accum   <= varlen_accum_next;
      varlen_count   <= varlen_count_next;
      running_status <= running_status_next;
      current_status <= current_status_next;
      held_data      <= held_data_next;
      meta_type      <= meta_type_next;
      skip_remaining <= skip_remaining_next;
      tempo_accum    <= tempo_accum_next;
      order_count    <= order_count_next;
    end
  end

  assign tick_ext = 64'(tick_total);

  // Output register: loaded on a transfer that yields a result.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= res.valid;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && res.valid) begin
      kind         <= res.kind;
      channel      <= res.channel;
      data_first   <= res.data_first;
      data_second  <= res.data_second;
      tempo_us     <= res.tempo_us;
      event_tick   <= tick_ext[mtep_pkg::EVT_TICK_W-1:0];
      order_number <= res.is_event ? order_count : 32'd0;
      error_code   <= res.error_code;
    end
  end

  // Checks on the parser's own sequencing.
  `ASSERT_NEXT(a_halt_sticky, phase == mtep_pkg::PH_HALT && !(take && cmd), phase == mtep_pkg::PH_HALT, "parser left the halted state without a chunk end")
  `ASSERT_NEXT(a_chunk_clear, take && cmd, phase == mtep_pkg::PH_DELTA && tick_total == '0 && running_status == 8'h00, "chunk end did not clear the parser")
  `ASSERT_NEXT(a_order_step, take && !cmd && res.ord_take && order_count != '1, order_count == $past(order_count) + 32'd1, "order counter did not advance on an event")
  `ASSERT_ALWAYS(a_varlen_bound, varlen_count < CNT_W'(VARLEN_MAX_BYTES), "variable-length byte count beyond its limit")
  `ASSERT_ALWAYS(a_error_no_order, !(out_valid && kind == mtep_pkg::K_ERROR) || order_number == 32'd0, "error result carries an order number")

endmodule

>>> tb/sv/tb_midi_track_event_parser.sv
`timescale 1ns / 1ps

module tb_midi_track_event_parser;

  localparam int          CYCLE_LIMIT = 2_000_000;
  localparam logic [47:0] TICK_MAX    = '1;
  localparam logic [7:0]  ST_TUNE_REQ = {mtep_pkg::OP_SYSTEM, 4'h6};
  localparam logic [7:0]  META_TEXT   = 8'h01;
  localparam logic [3:0]  OP_POLY_AT  = 4'hA;

  // One decoded result as it should appear on the output channel.
  typedef struct packed {
    logic [2:0]  kind;
    logic [3:0]  channel;
    logic [7:0]  data_first;
    logic [7:0]  data_second;
    logic [23:0] tempo_us;
    logic [47:0] event_tick;
    logic [31:0] order_number;
    logic [2:0]  error_code;
  } track_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        cmd = 1'b0;
  logic [7:0]  byte_value = 8'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  kind;
  logic [3:0]  channel;
  logic [7:0]  data_first;
  logic [7:0]  data_second;
  logic [23:0] tempo_us;
  logic [47:0] event_tick;
  logic [31:0] order_number;
  logic [2:0]  error_code;

  midi_track_event_parser i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .cmd          (cmd),
    .byte_value   (byte_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .kind         (kind),
    .channel      (channel),
    .data_first   (data_first),
    .data_second  (data_second),
    .tempo_us     (tempo_us),
    .event_tick   (event_tick),
    .order_number (order_number),
    .error_code   (error_code)
  );

  // Parser state as predicted by the testbench.
  logic [47:0]       trk_tick = '0;
  logic [34:0]       vq_accum = '0;
  int                vq_count = 0;
  logic [7:0]        run_status = '0;
  mtep_pkg::phase_t  parse_at = mtep_pkg::PH_DELTA;
  logic [7:0]        cur_status = '0;
  logic [7:0]        first_data = '0;
  logic [7:0]        meta_kind = '0;
  logic [31:0]       bytes_left = '0;
  logic [23:0]       tempo_acc = '0;
  logic [31:0]       next_order = '0;

  track_result_t expected_results[$];
  logic [8:0]    track_bytes[$];

  // Run control and statistics.
  int mismatches = 0;
  int results_seen = 0;
  int transfers = 0;
  int useful_transfers = 0;
  int in_stall_cycles = 0;
  int kind_seen[8];
  int burst_left = 0;
  bit sender_gaps = 1'b0;
  bit stall_on = 1'b0;
  int hold_request = 0;
  longint cycles = 0;

  // Clock.
  initial begin
    forever #10 clk = ~clk;
  end

  // Watchdog on the total run length.
  initial begin
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("%0t: run did not complete within %0d cycles", $time, CYCLE_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // Receiver: long hold-offs on request, otherwise either always ready or
  // alternating runs of ready and stalled cycles of random length.
  initial begin
    int  hold_left;
    int  run_left;
    bit  ready_level;
    hold_left = 0;
    run_left = 0;
    ready_level = 1'b1;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (!stall_on) begin
        out_ready <= 1'b1;
      end else begin
        if (run_left == 0) begin
          ready_level = !ready_level;
          run_left = ready_level ? $urandom_range(1, 10) : $urandom_range(1, 5);
        end
        run_left--;
        out_ready <= ready_level;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------

  function automatic void push_result(input logic [2:0] k, input logic [3:0] ch,
                                      input logic [7:0] d1, input logic [7:0] d2,
                                      input logic [23:0] tempo, input logic [31:0] ord,
                                      input logic [2:0] err);
    track_result_t r;
    r.kind         = k;
    r.channel      = ch;
    r.data_first   = d1;
    r.data_second  = d2;
    r.tempo_us     = tempo;
    r.event_tick   = trk_tick;
    r.order_number = ord;
    r.error_code   = err;
    expected_results = {expected_results, r};
  endfunction

  function automatic logic [31:0] claim_order();
    logic [31:0] n;
    n = next_order;
    if (next_order != 32'hFFFF_FFFF) next_order++;
    return n;
  endfunction

  function automatic void clear_chunk();
    trk_tick   = '0;
    vq_accum   = '0;
    vq_count   = 0;
    run_status = '0;
    parse_at   = mtep_pkg::PH_DELTA;
    cur_status = '0;
    first_data = '0;
    meta_kind  = '0;
    bytes_left = '0;
    tempo_acc  = '0;
  endfunction

  // An error result halts the parser until the chunk ends.
  function automatic void raise_error(input logic [2:0] code);
    push_result(mtep_pkg::K_ERROR, '0, '0, '0, '0, '0, code);
    parse_at = mtep_pkg::PH_HALT;
  endfunction

  // Variable-length quantity: 1 = complete, 0 = more bytes, -1 = malformed.
  function automatic int take_varlen(input logic [7:0] b, output logic [31:0] v);
    logic [34:0] full;
    v = '0;
    vq_accum = {vq_accum[27:0], b[6:0]};
    vq_count++;
    if (!b[7]) begin
      full = vq_accum;
      vq_accum = '0;
      vq_count = 0;
      if (full > 35'h0_FFFF_FFFF) return -1;
      v = full[31:0];
      return 1;
    end
    if (vq_count >= 5) begin
      vq_accum = '0;
      vq_count = 0;
      return -1;
    end
    return 0;
  endfunction

  function automatic void finish_meta();
    if (meta_kind == mtep_pkg::META_END) begin
      push_result(mtep_pkg::K_END, '0, '0, '0, '0, '0, '0);
      parse_at = mtep_pkg::PH_HALT;
    end else begin
      parse_at = mtep_pkg::PH_DELTA;
    end
  endfunction

  // Completion of a channel message once its data bytes are in.
  function automatic void finish_channel(input logic [7:0] d2);
    logic [3:0]  op;
    logic [3:0]  ch;
    logic [31:0] ord;
    op = cur_status[7:4];
    ch = cur_status[3:0];
    parse_at = mtep_pkg::PH_DELTA;
    if (op == mtep_pkg::OP_CHAN_AT) return;
    ord = claim_order();
    case (op)
      mtep_pkg::OP_PROGRAM: begin
        push_result(mtep_pkg::K_PROGRAM, ch, first_data, '0, '0, ord, '0);
      end
      mtep_pkg::OP_NOTE_OFF: begin
        push_result(mtep_pkg::K_NOTE_OFF, ch, first_data, d2, '0, ord, '0);
      end
      mtep_pkg::OP_NOTE_ON: begin
        push_result((d2 == 8'd0) ? mtep_pkg::K_NOTE_OFF : mtep_pkg::K_NOTE_ON,
                    ch, first_data, d2, '0, ord, '0);
      end
      mtep_pkg::OP_CONTROL: begin
        push_result(mtep_pkg::K_CONTROL, ch, first_data, d2, '0, ord, '0);
      end
      mtep_pkg::OP_BEND: begin
        push_result(mtep_pkg::K_BEND, ch, first_data, d2, '0, ord, '0);
      end
      default: ;  // polyphonic aftertouch only uses up an order number
    endcase
  endfunction

  function automatic void take_status(input logic [7:0] b);
    logic [7:0] st;
    bit         running;
    st = b;
    running = 1'b0;
    if (!b[7]) begin
      if (!run_status[7] || run_status[7:4] == mtep_pkg::OP_SYSTEM) begin
        raise_error(mtep_pkg::E_RUNNING);
        return;
      end
      first_data = b;
      st = run_status;
      running = 1'b1;
    end else if (b[7:4] != mtep_pkg::OP_SYSTEM) begin
      run_status = b;
    end else begin
      run_status = '0;
    end
    cur_status = st;
    if (st == mtep_pkg::ST_META) begin
      parse_at = mtep_pkg::PH_META_TYPE;
    end else if (st == mtep_pkg::ST_SYSEX || st == mtep_pkg::ST_SYSEX_ESC) begin
      parse_at = mtep_pkg::PH_SYSEX_LEN;
    end else if (st[7:4] == mtep_pkg::OP_SYSTEM) begin
      parse_at = mtep_pkg::PH_DELTA;
    end else if (st[7:4] == mtep_pkg::OP_PROGRAM || st[7:4] == mtep_pkg::OP_CHAN_AT) begin
      if (running) finish_channel('0);
      else parse_at = mtep_pkg::PH_DATA1;
    end else begin
      parse_at = running ? mtep_pkg::PH_DATA2 : mtep_pkg::PH_DATA1;
    end
  endfunction

  // Chunk end: the result depends on where in the stream it falls.
  function automatic void take_chunk_end();
    case (parse_at)
      mtep_pkg::PH_DELTA: begin
        if (vq_count != 0) begin
          push_result(mtep_pkg::K_ERROR, '0, '0, '0, '0, '0, mtep_pkg::E_DELTA);
        end else begin
          push_result(mtep_pkg::K_END, '0, '0, '0, '0, '0, '0);
        end
      end
      mtep_pkg::PH_STATUS: push_result(mtep_pkg::K_END, '0, '0, '0, '0, '0, '0);
      mtep_pkg::PH_META_TYPE: begin
        push_result(mtep_pkg::K_ERROR, '0, '0, '0, '0, '0, mtep_pkg::E_META);
      end
      mtep_pkg::PH_META_LEN, mtep_pkg::PH_META_SKIP, mtep_pkg::PH_TEMPO: begin
        push_result(mtep_pkg::K_ERROR, '0, '0, '0, '0, '0, mtep_pkg::E_META_LEN);
      end
      mtep_pkg::PH_SYSEX_LEN, mtep_pkg::PH_SYSEX_SKIP: begin
        push_result(mtep_pkg::K_ERROR, '0, '0, '0, '0, '0, mtep_pkg::E_SYSEX);
      end
      mtep_pkg::PH_DATA1, mtep_pkg::PH_DATA2: begin
        push_result(mtep_pkg::K_ERROR, '0, '0, '0, '0, '0, mtep_pkg::E_CHANNEL);
      end
      default: ;
    endcase
    clear_chunk();
  endfunction

  // Advances the predicted parser by one accepted transfer.
  function automatic void predict_transfer(input logic c, input logic [7:0] b);
    logic [31:0] v;
    int          r;
    if (c) begin
      take_chunk_end();
      return;
    end
    case (parse_at)
      mtep_pkg::PH_DELTA: begin
        r = take_varlen(b, v);
        if (r < 0) begin
          raise_error(mtep_pkg::E_DELTA);
        end else if (r > 0) begin
          if ({16'd0, v} > TICK_MAX - trk_tick) trk_tick = TICK_MAX;
          else trk_tick = trk_tick + {16'd0, v};
          parse_at = mtep_pkg::PH_STATUS;
        end
      end
      mtep_pkg::PH_STATUS: take_status(b);
      mtep_pkg::PH_META_TYPE: begin
        meta_kind = b;
        parse_at = mtep_pkg::PH_META_LEN;
      end
      mtep_pkg::PH_META_LEN: begin
        r = take_varlen(b, v);
        if (r < 0) begin
          raise_error(mtep_pkg::E_META_LEN);
        end else if (r > 0) begin
          bytes_left = v;
          tempo_acc = '0;
          if (meta_kind == mtep_pkg::META_TEMPO && v == 32'd3) parse_at = mtep_pkg::PH_TEMPO;
          else if (v == 32'd0) finish_meta();
          else parse_at = mtep_pkg::PH_META_SKIP;
        end
      end
      mtep_pkg::PH_META_SKIP: begin
        bytes_left = bytes_left - 1;
        if (bytes_left == 32'd0) finish_meta();
      end
      mtep_pkg::PH_TEMPO: begin
        tempo_acc = {tempo_acc[15:0], b};
        bytes_left = bytes_left - 1;
        if (bytes_left == 32'd0) begin
          parse_at = mtep_pkg::PH_DELTA;
          push_result(mtep_pkg::K_TEMPO, '0, '0, '0, tempo_acc, claim_order(), '0);
        end
      end
      mtep_pkg::PH_SYSEX_LEN: begin
        r = take_varlen(b, v);
        if (r < 0) begin
          raise_error(mtep_pkg::E_SYSEX);
        end else if (r > 0) begin
          bytes_left = v;
          parse_at = (v == 32'd0) ? mtep_pkg::PH_DELTA : mtep_pkg::PH_SYSEX_SKIP;
        end
      end
      mtep_pkg::PH_SYSEX_SKIP: begin
        bytes_left = bytes_left - 1;
        if (bytes_left == 32'd0) parse_at = mtep_pkg::PH_DELTA;
      end
      mtep_pkg::PH_DATA1: begin
        first_data = b;
        if (cur_status[7:4] == mtep_pkg::OP_PROGRAM ||
            cur_status[7:4] == mtep_pkg::OP_CHAN_AT) begin
          finish_channel('0);
        end else begin
          parse_at = mtep_pkg::PH_DATA2;
        end
      end
      mtep_pkg::PH_DATA2: finish_channel(b);
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // A transfer on the output happens at the next rising edge whenever valid
  // and ready are both high at the falling edge before it.
  initial begin
    track_result_t want;
    forever begin
      @(negedge clk);
      if (!rst && in_valid && !in_ready) in_stall_cycles++;
      if (!rst && out_valid && out_ready) begin
        results_seen++;
        kind_seen[kind]++;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual kind %0d tick %0h",
                   $time, kind, event_tick);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          check_field("kind", 64'(want.kind), 64'(kind));
          check_field("channel", 64'(want.channel), 64'(channel));
          check_field("data_first", 64'(want.data_first), 64'(data_first));
          check_field("data_second", 64'(want.data_second), 64'(data_second));
          check_field("tempo_us", 64'(want.tempo_us), 64'(tempo_us));
          check_field("event_tick", 64'(want.event_tick), 64'(event_tick));
          check_field("order_number", 64'(want.order_number), 64'(order_number));
          check_field("error_code", 64'(want.error_code), 64'(error_code));
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------

  // Offers one transfer and returns at the edge that accepts it.
  task automatic send_transfer(input logic c, input logic [7:0] b);
    int gap;
    if (sender_gaps && burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    if (burst_left > 0) burst_left--;
    in_valid   <= 1'b1;
    cmd        <= c;
    byte_value <= b;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
    transfers++;
    if (c || parse_at != mtep_pkg::PH_HALT) useful_transfers++;
    predict_transfer(c, b);
  endtask

  task automatic send_track_bytes();
    foreach (track_bytes[i]) send_transfer(track_bytes[i][8], track_bytes[i][7:0]);
    track_bytes.delete();
  endtask

  // Stops offering and waits until every predicted result has been taken.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic void add(input logic [7:0] b);
    logic [8:0] entry;
    entry = {1'b0, b};
    track_bytes = {track_bytes, entry};
  endfunction

  function automatic void add_end();
    logic [7:0] junk;
    logic [8:0] entry;
    junk = 8'($urandom_range(0, 255));
    entry = {1'b1, junk};
    track_bytes = {track_bytes, entry};
  endfunction

  function automatic void add_varlen(input logic [31:0] v);
    logic [7:0] grp[$];
    grp.push_front({1'b0, v[6:0]});
    v = v >> 7;
    while (v != 0) begin
      grp.push_front({1'b1, v[6:0]});
      v = v >> 7;
    end
    foreach (grp[i]) add(grp[i]);
  endfunction

  // Either five bytes that all continue, or a value above 32 bits.
  function automatic void add_bad_varlen();
    if ($urandom_range(0, 1) == 0) begin
      repeat (5) add(8'($urandom_range(128, 255)));
    end else begin
      add(8'($urandom_range(144, 255)));
      repeat (3) add(8'($urandom_range(128, 255)));
      add(8'($urandom_range(0, 127)));
    end
  endfunction

  function automatic logic [7:0] rand_byte();
    logic [7:0] v;
    v = 8'($urandom_range(0, 255));
    return v;
  endfunction

  // Data bytes: mostly in range, sometimes zero or with the top bit set.
  function automatic logic [7:0] rand_data();
    int         pick;
    logic [7:0] v;
    pick = $urandom_range(0, 19);
    if (pick == 0) v = 8'd0;
    else if (pick < 3) v = 8'($urandom_range(0, 255));
    else v = 8'($urandom_range(0, 127));
    return v;
  endfunction

  function automatic logic [31:0] rand_delta();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 7) return $urandom_range(0, 127);
    if (pick < 9) return $urandom_range(128, 16383);
    return $urandom;
  endfunction

  function automatic void add_channel_event();
    logic [3:0] op;
    logic [3:0] chn;
    if (run_status[7] && run_status[7:4] != mtep_pkg::OP_SYSTEM &&
        $urandom_range(0, 2) == 0) begin
      // Running status: the first data byte stands in for the status.
      op = run_status[7:4];
      add(8'($urandom_range(0, 127)));
    end else begin
      op = 4'($urandom_range(8, 14));
      chn = 4'($urandom_range(0, 15));
      add({op, chn});
      add(rand_data());
    end
    if (op != mtep_pkg::OP_PROGRAM && op != mtep_pkg::OP_CHAN_AT) add(rand_data());
  endfunction

  // One random event, well formed most of the time.
  function automatic void add_random_event();
    int         pick;
    int         len;
    logic [7:0] st;
    logic [3:0] nib;
    pick = $urandom_range(0, 99);
    if (pick >= 97) begin
      repeat ($urandom_range(1, 6)) add(rand_byte());
      return;
    end
    if (pick >= 87 && pick < 92) begin
      len = $urandom_range(0, 2);
      if (len > 0) add_varlen(rand_delta());
      if (len == 1) begin
        add(mtep_pkg::ST_META);
        add(rand_byte());
      end else if (len == 2) begin
        add(mtep_pkg::ST_SYSEX);
      end
      add_bad_varlen();
      return;
    end
    add_varlen(rand_delta());
    if (pick < 55) begin
      add_channel_event();
    end else if (pick < 63) begin
      add(mtep_pkg::ST_META);
      add(mtep_pkg::META_TEMPO);
      add_varlen(32'd3);
      repeat (3) add(rand_byte());
    end else if (pick < 71) begin
      st = rand_byte();
      if (st == mtep_pkg::META_END) st = mtep_pkg::META_TEMPO;
      add(mtep_pkg::ST_META);
      add(st);
      if ($urandom_range(0, 9) == 0) begin
        // Huge length: cut short by the chunk end.
        add_varlen($urandom_range(1024, 32'hFFFF_FFFF));
        repeat ($urandom_range(0, 4)) add(rand_byte());
        add_end();
      end else begin
        len = $urandom_range(0, 4);
        add_varlen(len);
        repeat (len) add(rand_byte());
      end
    end else if (pick < 78) begin
      add(($urandom_range(0, 1) == 0) ? mtep_pkg::ST_SYSEX : mtep_pkg::ST_SYSEX_ESC);
      if ($urandom_range(0, 9) == 0) begin
        add_varlen($urandom_range(1024, 32'hFFFF_FFFF));
        repeat ($urandom_range(0, 4)) add(rand_byte());
        add_end();
      end else begin
        len = $urandom_range(0, 5);
        add_varlen(len);
        repeat (len) add(rand_byte());
      end
    end else if (pick < 83) begin
      nib = 4'($urandom_range(1, 14));
      st = {mtep_pkg::OP_SYSTEM, nib};
      if (st == mtep_pkg::ST_SYSEX_ESC) st = ST_TUNE_REQ;
      add(st);
    end else if (pick < 87) begin
      add(mtep_pkg::ST_META);
      add(mtep_pkg::META_END);
      len = $urandom_range(0, 1);
      add_varlen(len);
      repeat (len) add(rand_byte());
    end else begin
      // A data byte where a status is needed, after the running status is gone.
      add(ST_TUNE_REQ);
      add_varlen(32'd0);
      add(8'($urandom_range(0, 127)));
    end
  endfunction

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  task automatic test_channel_messages();
    add_varlen(32'd0);
    add({mtep_pkg::OP_NOTE_ON, 4'h0}); add(8'h3C); add(8'h64);
    // Note on with zero velocity is reported as note off.
    add_varlen(32'd96);
    add({mtep_pkg::OP_NOTE_ON, 4'hF}); add(8'h7F); add(8'h00);
    // Data bytes with the top bit set are taken as they are.
    add_varlen(32'h0FFF_FFFF);
    add({mtep_pkg::OP_NOTE_OFF, 4'h1}); add(8'hFF); add(8'hFF);
    add_varlen(32'd1);
    add({mtep_pkg::OP_CONTROL, 4'h5}); add(8'h07); add(8'h7F);
    add_varlen(32'd0);
    add({mtep_pkg::OP_PROGRAM, 4'h9}); add(8'h00);
    add_varlen(32'd0);
    add({mtep_pkg::OP_BEND, 4'h3}); add(8'h00); add(8'h40);
    // Polyphonic aftertouch takes an order number; channel aftertouch does not.
    add_varlen(32'd0);
    add({OP_POLY_AT, 4'hF}); add(8'h3C); add(8'h10);
    add_varlen(32'd0);
    add({mtep_pkg::OP_CHAN_AT, 4'h2}); add(8'h55);
    add_varlen(32'hFFFF_FFFF);
    add({mtep_pkg::OP_NOTE_ON, 4'hA}); add(8'h7F); add(8'h01);
    add_end();
    send_track_bytes();
  endtask

  task automatic test_meta_and_sysex();
    add_varlen(32'd10);
    add(mtep_pkg::ST_META); add(mtep_pkg::META_TEMPO); add_varlen(32'd3);
    add(8'h07); add(8'hA1); add(8'h20);
    add_varlen(32'd0);
    add(mtep_pkg::ST_META); add(mtep_pkg::META_TEMPO); add_varlen(32'd3);
    add(8'hFF); add(8'hFF); add(8'hFF);
    // Tempo meta events of any other length are skipped.
    add_varlen(32'd0);
    add(mtep_pkg::ST_META); add(mtep_pkg::META_TEMPO); add_varlen(32'd0);
    add_varlen(32'd0);
    add(mtep_pkg::ST_META); add(mtep_pkg::META_TEMPO); add_varlen(32'd4);
    repeat (4) add(rand_byte());
    add_varlen(32'd0);
    add(mtep_pkg::ST_META); add(META_TEXT); add_varlen(32'd2); add(8'h41); add(8'h42);
    add_varlen(32'd0);
    add(mtep_pkg::ST_SYSEX); add_varlen(32'd3); add(8'h7E); add(8'h7F);
    add(mtep_pkg::ST_SYSEX_ESC);
    add_varlen(32'd0);
    add(mtep_pkg::ST_SYSEX_ESC); add_varlen(32'd0);
    add_varlen(32'd0);
    add(mtep_pkg::ST_SYSEX); add_varlen(32'd130);
    repeat (130) add(rand_byte());
    add_varlen(32'd0);
    add(ST_TUNE_REQ);
    add_varlen(32'd5);
    add(mtep_pkg::ST_META); add(mtep_pkg::META_END); add_varlen(32'd0);
    // Bytes after the track end are consumed silently, as is the chunk end.
    add({mtep_pkg::OP_NOTE_ON, 4'h0}); add(8'h3C); add(8'h40);
    add_end();
    // Track end with a non-empty payload.
    add_varlen(32'd7);
    add(mtep_pkg::ST_META); add(mtep_pkg::META_END); add_varlen(32'd2);
    add(8'h00); add(8'hFF);
    add_end();
    send_track_bytes();
  endtask

  task automatic test_running_status();
    // Data byte at the very start of a chunk: no running status yet.
    add_varlen(32'd0); add(8'h40);
    add_end();
    add_varlen(32'd0); add({mtep_pkg::OP_NOTE_ON, 4'h2}); add(8'h40); add(8'h50);
    add_varlen(32'd3); add(8'h41); add(8'h51);
    add_varlen(32'd0); add({mtep_pkg::OP_PROGRAM, 4'h4}); add(8'h05);
    add_varlen(32'd0); add(8'h06);
    add_varlen(32'd0); add({mtep_pkg::OP_CHAN_AT, 4'h1}); add(8'h20);
    add_varlen(32'd0); add(8'h21);
    add_varlen(32'd0); add({mtep_pkg::OP_BEND, 4'h6}); add(8'h7F); add(8'h7F);
    add_varlen(32'd0); add(8'h00); add(8'h00);
    // A system status clears the running status.
    add_varlen(32'd0); add(ST_TUNE_REQ);
    add_varlen(32'd0); add(8'h40);
    add_end();
    // So does a meta event.
    add_varlen(32'd0); add({mtep_pkg::OP_CONTROL, 4'h0}); add(8'h01); add(8'h02);
    add_varlen(32'd0); add(mtep_pkg::ST_META); add(META_TEXT); add_varlen(32'd0);
    add_varlen(32'd0); add(8'h05);
    add_end();
    send_track_bytes();
  endtask

  task automatic test_malformed_lengths();
    // Largest delta, then one that does not fit 32 bits.
    add(8'h8F); add(8'hFF); add(8'hFF); add(8'hFF); add(8'h7F);
    add(ST_TUNE_REQ);
    add(8'h90); add(8'h80); add(8'h80); add(8'h80); add(8'h00);
    add_end();
    // Continuation bit still set on the fifth byte.
    repeat (5) add(8'h80);
    add_end();
    add_varlen(32'd0); add(mtep_pkg::ST_META); add(META_TEXT);
    repeat (5) add(8'hFF);
    add_end();
    add_varlen(32'd0); add(mtep_pkg::ST_SYSEX);
    add(8'hFF); add(8'h80); add(8'h80); add(8'h80); add(8'h7F);
    add_end();
    send_track_bytes();
  endtask

  task automatic test_chunk_ends();
    // Empty chunk and a chunk ending right after a delta give track ends.
    add_end();
    add_varlen(32'd9); add_end();
    add(8'h81); add_end();
    add_varlen(32'd0); add(mtep_pkg::ST_META); add_end();
    add_varlen(32'd0); add(mtep_pkg::ST_META); add(META_TEXT); add_end();
    add_varlen(32'd0); add(mtep_pkg::ST_META); add(META_TEXT); add(8'h81); add_end();
    add_varlen(32'd0); add(mtep_pkg::ST_META); add(META_TEXT); add_varlen(32'hFFFF_FFFF);
    add(8'h41); add(8'h42); add_end();
    add_varlen(32'd0); add(mtep_pkg::ST_META); add(mtep_pkg::META_TEMPO); add_varlen(32'd3);
    add(8'h01);
    add_end();
    add_varlen(32'd0); add(mtep_pkg::ST_SYSEX); add_end();
    add_varlen(32'd0); add(mtep_pkg::ST_SYSEX); add_varlen(32'd5); add(8'h01); add_end();
    add_varlen(32'd0); add({mtep_pkg::OP_NOTE_ON, 4'h0}); add_end();
    add_varlen(32'd0); add({mtep_pkg::OP_NOTE_ON, 4'h0}); add(8'h3C); add_end();
    add_varlen(32'd0); add({mtep_pkg::OP_PROGRAM, 4'h0}); add_end();
    send_track_bytes();
  endtask

  // The receiver holds off while a stream of control changes keeps coming,
  // so the output register fills and the input is stalled.
  task automatic test_backpressure();
    logic [3:0] chn;
    sender_gaps = 1'b0;
    stall_on = 1'b0;
    hold_request = 60;
    repeat (30) begin
      chn = 4'($urandom_range(0, 15));
      add_varlen(32'd0);
      add({mtep_pkg::OP_CONTROL, chn}); add(rand_data()); add(rand_data());
    end
    add_end();
    send_track_bytes();
    wait_drained();
  endtask

  task automatic test_random_tracks();
    int  start;
    int  n_ev;
    int  cut;
    int  e;
    bit  closed;
    start = useful_transfers;
    while (useful_transfers - start < 100 || results_seen < 60) begin
      sender_gaps = ($urandom_range(0, 3) != 0);
      stall_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 19) == 0) hold_request = $urandom_range(20, 60);
      n_ev = $urandom_range(1, 14);
      closed = 1'b0;
      for (e = 0; e < n_ev && !closed; e++) begin
        add_random_event();
        if ($urandom_range(0, 99) < 6) begin
          // Truncate the event by ending the chunk part of the way through.
          cut = $urandom_range(0, track_bytes.size() - 1);
          while (track_bytes.size() > cut) void'(track_bytes.pop_back());
          add_end();
        end
        closed = track_bytes[track_bytes.size() - 1][8];
        send_track_bytes();
      end
      if (!closed) begin
        if (parse_at == mtep_pkg::PH_HALT) repeat ($urandom_range(0, 3)) add(rand_byte());
        add_end();
        send_track_bytes();
      end
    end
  endtask

  // ---------------------------------------------------------------------
  // Sequence of tests
  // ---------------------------------------------------------------------

  initial begin
    int n;
    foreach (kind_seen[i]) kind_seen[i] = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_channel_messages();
    test_meta_and_sysex();
    test_running_status();
    test_malformed_lengths();
    test_chunk_ends();
    test_backpressure();
    test_random_tracks();

    // Let the last results drain, then allow for the output register.
    in_valid <= 1'b0;
    for (n = 0; n < 1000 && expected_results.size() != 0; n++) @(posedge clk);
    repeat (8) @(posedge clk);
    if (expected_results.size() != 0) begin
      $display("%0t: %0d results expected but never delivered, next kind %0d",
               $time, expected_results.size(), expected_results[0].kind);
      mismatches++;
    end

    $display("Covered %0d input transfers and %0d results: %0d events, %0d track ends, %0d errors.",
             transfers, results_seen,
             kind_seen[mtep_pkg::K_NOTE_ON] + kind_seen[mtep_pkg::K_NOTE_OFF] +
             kind_seen[mtep_pkg::K_PROGRAM] + kind_seen[mtep_pkg::K_CONTROL] +
             kind_seen[mtep_pkg::K_BEND] + kind_seen[mtep_pkg::K_TEMPO],
             kind_seen[mtep_pkg::K_END], kind_seen[mtep_pkg::K_ERROR]);
    $display("Input stalled for %0d cycles under output back-pressure and random gaps.",
             in_stall_cycles);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
